// ===== rtl/core/fmp_pkg.sv =====
// Package with the shared widths and the overflow threshold for the Fibonacci pipeline.
`default_nettype none
package fmp_pkg;

  localparam int INDEX_BITS_DEF = 8;
  localparam int VALUE_BITS_DEF = 64;

  // Largest index whose Fibonacci number fits in vb bits; evaluated at elaboration.
  function automatic int last_fit(input int vb);
    logic [64:0] a;
    logic [64:0] b;
    logic [64:0] c;
    logic [64:0] lim;
    int          k;
    bit          done;
    a    = 65'd0;
    b    = 65'd1;
    lim  = (65'd1 << vb) - 65'd1;
    k    = 1;
    done = 1'b0;
    for (int i = 0; i < 200; i++) begin
      c = a + b;
      if (!done) begin
        if (c > lim) begin
          done = 1'b1;
        end else begin
          a = b;
          b = c;
          k = k + 1;
        end
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fmp_bit_stage.sv =====
// One exponent bit of fast doubling: a partial product stage and a combine stage.
`default_nettype none
module fmp_bit_stage
  import fmp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int BIT        = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire logic [INDEX_BITS-1:0] in_e,
  input  wire logic                  in_zero,
  input  wire logic                  in_ovf,
  input  wire logic [VALUE_BITS-1:0] in_a,
  input  wire logic [VALUE_BITS-1:0] in_b,
  output logic                       out_valid,
  output logic [INDEX_BITS-1:0]      out_e,
  output logic                       out_zero,
  output logic                       out_ovf,
  output logic [VALUE_BITS-1:0]      out_a,
  output logic [VALUE_BITS-1:0]      out_b
);

  localparam int LO = (VALUE_BITS + 1) / 2;
  localparam int HI = VALUE_BITS - LO;

  logic [VALUE_BITS-1:0] t;
  logic [VALUE_BITS-1:0] xs [3];
  logic [VALUE_BITS-1:0] ys [3];
  logic [2*LO-1:0]       pl_next [3];
  logic [HI-1:0]         pc_next [3];

  logic                  p_valid;
  logic [INDEX_BITS-1:0] p_e;
  logic                  p_zero;
  logic                  p_ovf;
  logic [2*LO-1:0]       pl [3];
  logic [HI-1:0]         pc [3];

  logic [VALUE_BITS-1:0] prod [3];
  logic [VALUE_BITS-1:0] f2k;
  logic [VALUE_BITS-1:0] f2k1;
  logic [VALUE_BITS-1:0] a_next;
  logic [VALUE_BITS-1:0] b_next;

  // F(2k) = a*(2b-a), F(2k+1) = a*a + b*b, each product modulo 2^VALUE_BITS.
  always_comb begin
    t     = (in_b << 1) - in_a;
    xs[0] = in_a;
    ys[0] = t;
    xs[1] = in_a;
    ys[1] = in_a;
    xs[2] = in_b;
    ys[2] = in_b;
    for (int j = 0; j < 3; j++) begin
      pl_next[j] = (2*LO)'(xs[j][LO-1:0]) * (2*LO)'(ys[j][LO-1:0]);
      pc_next[j] = HI'(HI'(xs[j][VALUE_BITS-1:LO]) * HI'(ys[j][LO-1:0]))
                 + HI'(HI'(xs[j][LO-1:0]) * HI'(ys[j][VALUE_BITS-1:LO]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
    end
    if (adv) begin
      p_e    <= in_e;
      p_zero <= in_zero;
      p_ovf  <= in_ovf;
      pl     <= pl_next;
      pc     <= pc_next;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod[j] = VALUE_BITS'(pl[j]) + {pc[j], {LO{1'b0}}};
    end
    f2k  = prod[0];
    f2k1 = prod[1] + prod[2];
    if (p_e[BIT]) begin
      a_next = f2k1;
      b_next = f2k + f2k1;
    end else begin
      a_next = f2k;
      b_next = f2k1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
    if (adv) begin
      out_e    <= p_e;
      out_zero <= p_zero;
      out_ovf  <= p_ovf;
      out_a    <= a_next;
      out_b    <= b_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fibonacci_matrix_power.sv =====
// Top level of the pipelined Fibonacci number unit.
//
// Each word on the input stream carries an index n and yields one word with fib(n) modulo
// 2^VALUE_BITS and a flag that is set when the true value does not fit. The exponent n-1 is
// walked from its top bit down by fast doubling on the pair (F(k), F(k+1)), which equals the
// entries of the powered matrix [[1,1],[1,0]]. Every exponent bit owns two register stages
// (three split multiplications, then their sums), ahead of the output register, and a new
// index is accepted every cycle while the output word is not waiting.
// The whole pipeline holds when the output word waits.
`default_nettype none
module fibonacci_matrix_power
  import fmp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0: index.
  input  wire logic [((INDEX_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // Fields from bit 0: value.
  output logic [((VALUE_BITS+7)/8)*8-1:0]          m_tdata,
  // Fields from bit 0: overflow.
  output logic                                     m_tuser
);

  localparam int IN_W   = ((INDEX_BITS+7)/8)*8;
  localparam int OUT_W  = ((VALUE_BITS+7)/8)*8;
  localparam int LAST   = last_fit(VALUE_BITS);

  logic                  adv;
  logic [INDEX_BITS-1:0] n;

  logic                  v_s [INDEX_BITS+1];
  logic [INDEX_BITS-1:0] e_s [INDEX_BITS+1];
  logic                  z_s [INDEX_BITS+1];
  logic                  o_s [INDEX_BITS+1];
  logic [VALUE_BITS-1:0] a_s [INDEX_BITS+1];
  logic [VALUE_BITS-1:0] b_s [INDEX_BITS+1];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign n        = s_tdata[INDEX_BITS-1:0];

  assign v_s[0] = s_tvalid;
  assign e_s[0] = n - INDEX_BITS'(1);
  assign z_s[0] = (n == '0);
  assign o_s[0] = (32'(n) > 32'(LAST));
  assign a_s[0] = '0;
  assign b_s[0] = VALUE_BITS'(1);

  for (genvar i = 0; i < INDEX_BITS; i++) begin : g_bit
    fmp_bit_stage #(
      .INDEX_BITS (INDEX_BITS),
      .VALUE_BITS (VALUE_BITS),
      .BIT        (INDEX_BITS - 1 - i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (v_s[i]),
      .in_e      (e_s[i]),
      .in_zero   (z_s[i]),
      .in_ovf    (o_s[i]),
      .in_a      (a_s[i]),
      .in_b      (b_s[i]),
      .out_valid (v_s[i+1]),
      .out_e     (e_s[i+1]),
      .out_zero  (z_s[i+1]),
      .out_ovf   (o_s[i+1]),
      .out_a     (a_s[i+1]),
      .out_b     (b_s[i+1])
    );
  end

  logic out_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v_s[INDEX_BITS];
    end
    if (adv) begin
      m_tdata  <= OUT_W'(z_s[INDEX_BITS] ? '0 : b_s[INDEX_BITS]);
      m_tuser  <= o_s[INDEX_BITS];
      out_zero <= z_s[INDEX_BITS];
    end
  end

  logic unused_hi;
  assign unused_hi = ^s_tdata[IN_W-1:0];

  a_reset_idle : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_zero_value : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_zero |-> (m_tdata == '0) && !m_tuser)
    else $error("index zero gave nonzero result");

  a_enter : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> g_bit[0].u_stage.p_valid)
    else $error("accepted word did not enter the pipeline");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the Fibonacci matrix power unit with a self-checking scoreboard.
`default_nettype none
module tb_top;
  import fmp_pkg::*;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int VAL_W = VALUE_BITS_DEF;
  localparam int LATENCY = 2 * IDX_W + 1;

  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
  } fib_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  fib_result_t expected_fibs[$];
  int          fail_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  bit          sink_stall_on = 1'b1;

  fibonacci_matrix_power i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 2x2 product modulo 2^64, row-major.
  function automatic void mat_mult(inout logic [63:0] m[4], input logic [63:0] r[4]);
    logic [63:0] p[4];
    p[0] = m[0] * r[0] + m[1] * r[2];
    p[1] = m[0] * r[1] + m[1] * r[3];
    p[2] = m[2] * r[0] + m[3] * r[2];
    p[3] = m[2] * r[1] + m[3] * r[3];
    m = p;
  endfunction

  function automatic fib_result_t fib_predict(input logic [IDX_W-1:0] n);
    fib_result_t r;
    logic [63:0] acc[4];
    logic [63:0] sq[4];
    logic [63:0] base[4];
    logic [IDX_W-1:0] e;
    r.value = '0;
    r.overflow = 1'b0;
    if (n != 0) begin
      e = n - 1'b1;
      acc = '{64'd1, 64'd0, 64'd0, 64'd1};
      base = '{64'd1, 64'd1, 64'd1, 64'd0};
      for (int b = IDX_W - 1; b >= 0; b--) begin
        sq = acc;
        mat_mult(acc, sq);
        if (e[b]) mat_mult(acc, base);
      end
      r.value = acc[0];
      r.overflow = (n > 93);
    end
    return r;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_index(input logic [IDX_W-1:0] n);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tdata <= 8'(n);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_fibs.push_back(fib_predict(n));
    words_sent++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_stall_on) begin
      m_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fib_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fibs.size() == 0) begin
        $error("unexpected word: value=%0h overflow=%0b", m_tdata, m_tuser);
        fail_count++;
      end else begin
        e = expected_fibs.pop_front();
        if (m_tdata !== e.value) begin
          $error("value: expected %0h actual %0h", e.value, m_tdata);
          fail_count++;
        end
        if (m_tuser !== e.overflow) begin
          $error("overflow: expected %0b actual %0b", e.overflow, m_tuser);
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  task automatic test_directed();
    logic [IDX_W-1:0] picks[$] = '{0, 1, 2, 3, 4, 5, 10, 12, 47, 48, 92, 93, 94, 95,
                                   128, 200, 254, 255, 8'h55, 8'hAA};
    foreach (picks[i]) send_index(picks[i]);
  endtask

  task automatic test_back_to_back();
    sink_stall_on = 1'b0;
    for (int i = 0; i < 50; i++) begin
      @(negedge clk);
      s_tdata <= 8'($urandom_range(0, 255));
      s_tvalid <= 1'b1;
      do @(posedge clk); while (!s_tready);
      expected_fibs.push_back(fib_predict(s_tdata));
      words_sent++;
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    sink_stall_on = 1'b1;
  endtask

  task automatic test_random();
    for (int i = 0; i < 1480; i++) begin
      if ($urandom_range(0, 3) == 0) send_index(IDX_W'($urandom_range(90, 97)));
      else send_index(IDX_W'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_back_to_back();
    test_random();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_fibs.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d of %0d indices: extremes, the overflow boundary,", words_checked,
             words_sent);
    $display("back-to-back streaming and random traffic with stalls on both sides.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
